### src/mf3_pkg.sv
package mf3_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int WIN           = 3;
    localparam int CH_W          = 8;
    localparam int PIX_W         = 3 * CH_W;
    localparam int FW_W          = 11;
    localparam int FH_W          = 12;
    localparam int BV_W          = 8;
    localparam int LEAD_W        = FW_W + 1;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_VALUE = CFG_IDX_W'(2);

    localparam logic [FW_W-1:0] WIDTH_RST  = FW_W'(128);
    localparam logic [FH_W-1:0] HEIGHT_RST = FH_W'(128);
    localparam logic [BV_W-1:0] BORDER_RST = BV_W'(255);

    localparam logic CMD_FLUSH = 1'b1;

    typedef logic [CH_W-1:0]  chan_t;
    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [WIN-1:0]   col_t;
    typedef col_t [WIN-1:0]   win_t;
    typedef chan_t [WIN*WIN-1:0] nine_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic row_lo_ok;
        logic row_hi_ok;
        logic col_lo_ok;
        logic col_hi_ok;
    } pos_t;

    function automatic chan_t min2(input chan_t a, input chan_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic chan_t max2(input chan_t a, input chan_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic chan_t min3(input chan_t a, input chan_t b, input chan_t c);
        return min2(min2(a, b), c);
    endfunction

    function automatic chan_t max3(input chan_t a, input chan_t b, input chan_t c);
        return max2(max2(a, b), c);
    endfunction

    function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // column sort, then median of (max of lows, median of mids, min of highs)
    function automatic chan_t median9(input nine_t v);
        chan_t [WIN-1:0] lo;
        chan_t [WIN-1:0] md;
        chan_t [WIN-1:0] hi;
        for (int k = 0; k < WIN; k++) begin
            lo[k] = min3(v[k*WIN], v[k*WIN+1], v[k*WIN+2]);
            md[k] = med3(v[k*WIN], v[k*WIN+1], v[k*WIN+2]);
            hi[k] = max3(v[k*WIN], v[k*WIN+1], v[k*WIN+2]);
        end
        return med3(max3(lo[0], lo[1], lo[2]), med3(md[0], md[1], md[2]),
                    min3(hi[0], hi[1], hi[2]));
    endfunction

endpackage

### src/mf3_ram.sv
module mf3_ram
    import mf3_pkg::*;
#(
    parameter int DATA_W = PIX_W,
    parameter int DEPTH  = MAX_WIDTH_DEF
)
(
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/mf3_pos.sv
module mf3_pos
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic                         restart,
    input  logic [FW_W-1:0]              eff_width,
    input  logic [FH_W-1:0]              eff_height,
    output logic [$clog2(MAX_WIDTH)-1:0] wr_col,
    output pos_t                         pos
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [AW-1:0]     col_reg, col_next;
    logic [AW-1:0]     ocol_reg, ocol_next;
    logic [FH_W-1:0]   orow_reg, orow_next;
    logic [LEAD_W-1:0] lead_reg, lead_next;
    logic [FW_W-1:0]   w_last;
    logic [FH_W-1:0]   h_last;
    logic [LEAD_W-1:0] lead_full;
    logic              col_wrap;
    logic              ocol_wrap;

    always_comb begin
        w_last    = eff_width - FW_W'(1);
        h_last    = eff_height - FH_W'(1);
        lead_full = LEAD_W'(eff_width) + LEAD_W'(1);
        col_wrap  = 32'(col_reg) == 32'(w_last);
        ocol_wrap = 32'(ocol_reg) == 32'(w_last);

        pos.emit      = lead_reg == lead_full;
        pos.last      = pos.emit && ocol_wrap && (orow_reg == h_last);
        pos.row_lo_ok = orow_reg != '0;
        pos.row_hi_ok = orow_reg != h_last;
        pos.col_lo_ok = ocol_reg != '0;
        pos.col_hi_ok = !ocol_wrap;

        col_next  = col_wrap ? '0 : col_reg + AW'(1);
        lead_next = pos.emit ? lead_reg : lead_reg + LEAD_W'(1);
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (pos.emit) begin
            if (ocol_wrap) begin
                ocol_next = '0;
                orow_next = orow_reg + FH_W'(1);
            end else begin
                ocol_next = ocol_reg + AW'(1);
            end
        end
        if (pos.last) begin
            col_next  = '0;
            lead_next = '0;
            ocol_next = '0;
            orow_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg  <= '0;
            lead_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
        end else if (step) begin
            col_reg  <= col_next;
            lead_reg <= lead_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
        end
    end

    assign wr_col = col_reg;

endmodule

### src/mf3_window.sv
module mf3_window
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                         aclk,
    input  logic                         accept,
    input  logic                         s1_move,
    input  pix_t                         in_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0] in_addr,
    input  pos_t                         in_pos,
    output pos_t                         s1_pos,
    output pos_t                         s2_pos,
    output win_t                         win
);

    localparam int AW = $clog2(MAX_WIDTH);

    pix_t    s1_pixel_reg;
    logic [AW-1:0] s1_addr_reg;
    pos_t    s1_pos_reg;
    logic    s1_hit_reg, s1_hit_next;
    pix_t    byp_mid_reg;
    pix_t    byp_up_reg;
    win_t    win_reg;
    pos_t    s2_pos_reg;
    pix_t    mid_rd, up_rd;
    pix_t    mid_eff, up_eff;

    // same column written at the edge that sampled the read
    assign s1_hit_next = s1_move && (s1_addr_reg == in_addr);
    assign mid_eff     = s1_hit_reg ? byp_mid_reg : mid_rd;
    assign up_eff      = s1_hit_reg ? byp_up_reg : up_rd;

    mf3_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_middle_line (
        .aclk    (aclk),
        .wr_en   (s1_move),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_pixel_reg),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (mid_rd)
    );

    mf3_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_upper_line (
        .aclk    (aclk),
        .wr_en   (s1_move),
        .wr_addr (s1_addr_reg),
        .wr_data (mid_eff),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (up_rd)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pixel_reg <= in_pixel;
            s1_addr_reg  <= in_addr;
            s1_pos_reg   <= in_pos;
            s1_hit_reg   <= s1_hit_next;
            byp_mid_reg  <= s1_pixel_reg;
            byp_up_reg   <= mid_eff;
        end
        if (s1_move) begin
            win_reg    <= {{s1_pixel_reg, mid_eff, up_eff}, win_reg[WIN-1:1]};
            s2_pos_reg <= s1_pos_reg;
        end
    end

    assign s1_pos = s1_pos_reg;
    assign s2_pos = s2_pos_reg;
    assign win    = win_reg;

endmodule

### src/mf3_median.sv
module mf3_median
    import mf3_pkg::*;
(
    input  win_t  win,
    input  pos_t  pos,
    input  chan_t border_value,
    output pix_t  med
);

    logic [WIN-1:0] col_ok;
    logic [WIN-1:0] row_ok;
    pix_t           fill;
    pix_t           pix;
    nine_t [2:0]    taps;

    always_comb begin
        fill   = {border_value, border_value, border_value};
        col_ok = {pos.col_hi_ok, 1'b1, pos.col_lo_ok};
        row_ok = {pos.row_hi_ok, 1'b1, pos.row_lo_ok};
        pix    = fill;
        taps   = '0;
        for (int c = 0; c < WIN; c++) begin
            for (int r = 0; r < WIN; r++) begin
                pix = (col_ok[c] && row_ok[r]) ? win[c][r] : fill;
                for (int ch = 0; ch < 3; ch++) begin
                    taps[ch][c*WIN+r] = pix[ch*CH_W +: CH_W];
                end
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            med[ch*CH_W +: CH_W] = median9(taps[ch]);
        end
    end

endmodule

### src/median_3x3_pixel_filter.sv
// channel  dir  fields, low bit up                                  transfer
// s_       in   tdata: blue, green, red / tuser: command            s_tvalid & s_tready
// m_       out  tdata: out_blue, out_green, out_red / tlast: frame_end
// cfg_     in   index 0 frame_width, 1 frame_height, 2 border_value  cfg_valid & cfg_ready
//
// one item per clock unless the output stalls; after its input transfer a result passes:
// line store read, window register, then the median network into the output register
// a frame of W*H pixels is followed by W+1 flush items; pixel p leaves with item p+W+1
// aresetn clears the pipeline and position counters and loads 128x128 with border 255
// while the output waits, items keep entering until a second result waits in the window
// stage and one more item is held at the line store read
module median_3x3_pixel_filter
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // blue, green, red
    input  logic                  s_tuser,   // command

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,   // out_blue, out_green, out_red
    output logic                  m_tlast,   // frame_end

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    logic [BV_W-1:0] border_reg;
    logic [FW_W-1:0] eff_width;
    logic [FH_W-1:0] eff_height;
    logic            cfg_write;
    logic            cfg_known;
    logic            restart;

    logic            s1_valid_reg;
    logic            s2_valid_reg;
    logic            m_valid_reg;
    pix_t            m_data_reg;
    logic            m_last_reg;

    logic            out_free;
    logic            s2_free;
    logic            s1_move;
    logic            s2_adv;
    logic            accept;
    pix_t            in_pixel;
    logic [AW-1:0]   wr_col;
    pos_t            in_pos;
    pos_t            s1_pos;
    pos_t            s2_pos;
    win_t            win;
    pix_t            med;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign restart   = cfg_write && cfg_known;

    always_comb begin
        case (cfg_index)
            CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_BORDER_VALUE: cfg_known = 1'b1;
            default: cfg_known = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            border_reg <= BORDER_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
                CFG_BORDER_VALUE: border_reg <= cfg_data[BV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            eff_width = FW_W'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            eff_width = FW_W'(MAX_WIDTH);
        end else begin
            eff_width = width_reg;
        end
        eff_height = (height_reg == '0) ? FH_W'(1) : height_reg;
    end

    // stage handshake
    assign out_free = !m_valid_reg || m_tready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || s2_free;
    assign accept   = s_tvalid && s_tready;
    assign in_pixel = (s_tuser == CMD_FLUSH) ? '0 : s_tdata;

    mf3_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (accept),
        .restart    (restart),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .wr_col     (wr_col),
        .pos        (in_pos)
    );

    mf3_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .aclk     (aclk),
        .accept   (accept),
        .s1_move  (s1_move),
        .in_pixel (in_pixel),
        .in_addr  (wr_col),
        .in_pos   (in_pos),
        .s1_pos   (s1_pos),
        .s2_pos   (s2_pos),
        .win      (win)
    );

    mf3_median u_median (
        .win          (win),
        .pos          (s2_pos),
        .border_value (border_reg),
        .med          (med)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move) begin
                s2_valid_reg <= s1_pos.emit;
            end else if (s2_adv) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            m_data_reg <= med;
            m_last_reg <= s2_pos.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with an empty output register");

    a_pending_is_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> s2_pos.emit)
        else $error("pending window holds an item without a result");

    a_result_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_move && s1_pos.emit) |=> s2_valid_reg)
        else $error("result lost between line store and window");

endmodule
